// ===== rtl/accumulator_cpu_step_unit_defines.svh =====
`ifndef ACCUMULATOR_CPU_STEP_UNIT_DEFINES_SVH
`define ACCUMULATOR_CPU_STEP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define ACS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acs assertion failed");

// next-cycle implication
`define ACS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acs assertion failed");

`endif

// ===== rtl/acs_pkg.sv =====
`timescale 1ns / 1ps

package acs_pkg;

  localparam int MEM_WORDS_DEF  = 1024;
  localparam int IO_DEVICES_DEF = 16;

  typedef enum logic [4:0] {
    OP_NOP, OP_HALT, OP_LOADI, OP_LOADM, OP_LOADX, OP_STOREM, OP_STOREX,
    OP_MOVAX, OP_MOVXA, OP_INCX, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
    OP_NEG, OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JP, OP_CALL, OP_RET, OP_IN,
    OP_OUT, OP_SYSCALL
  } opcode_t;

  localparam logic [31:0] OPC_LAST = 32'd25;

  typedef enum logic [2:0] {
    ERR_OK, ERR_ADDR, ERR_DEV, ERR_PRIV, ERR_HALT, ERR_INV, ERR_SYS, ERR_DIV0
  } err_t;

  typedef enum logic [1:0] {
    REQ_WRITE, REQ_EXEC, REQ_SETPC, REQ_NONE
  } req_op_t;

  typedef enum logic [1:0] {
    MODE_SUP, MODE_USER, MODE_ZOMBIE, MODE_RSVD
  } mode_t;

  typedef struct packed {
    logic take;
    logic act;
    logic fetch;
    logic latch_opc;
    logic decode;
    logic latch_arg;
    logic exec1;
    logic latch_m;
    logic exec2;
    logic div_wait;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic exec_go;
    logic fetch_go;
    logic arg_go;
    logic mem_go;
    logic div_go;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/acs_if.sv =====
`timescale 1ns / 1ps

interface acs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [9:0]         address;
  logic signed [31:0] value;
  logic signed [31:0] io_read_value;
  modport source(output valid, op, address, value, io_read_value, input ready);
  modport sink(input valid, op, address, value, io_read_value, output ready);
endinterface

interface acs_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] error_detail;
  logic signed [31:0] program_counter;
  logic signed [31:0] accumulator;
  logic signed [31:0] index_value;
  logic               io_read_taken;
  logic               io_write_valid;
  logic [3:0]         io_device;
  logic signed [31:0] io_write_value;
  modport source(output valid, status, error_detail, program_counter, accumulator,
                 index_value, io_read_taken, io_write_valid, io_device,
                 io_write_value, input ready);
  modport sink(input valid, status, error_detail, program_counter, accumulator,
               index_value, io_read_taken, io_write_valid, io_device,
               io_write_value, output ready);
endinterface

interface acs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/acs_ram.sv =====
`timescale 1ns / 1ps

module acs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/acs_div.sv =====
`timescale 1ns / 1ps

// signed 32-bit divide, one quotient bit per cycle
module acs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_mod,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] result
);

  logic        busy;
  logic [4:0]  cnt;
  logic [32:0] r;
  logic [31:0] q;
  logic [31:0] d;
  logic        neg_q;
  logic        neg_r;
  logic        mod_sel;
  logic [32:0] t;
  logic [32:0] sub;
  logic [31:0] abs_n;
  logic [31:0] abs_d;

  assign abs_n = dividend[31] ? 32'd0 - dividend : dividend;
  assign abs_d = divisor[31] ? 32'd0 - divisor : divisor;
  assign t     = {r[31:0], q[31]};
  assign sub   = t - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= 5'd31;
        r       <= '0;
        q       <= abs_n;
        d       <= abs_d;
        neg_q   <= dividend[31] ^ divisor[31];
        neg_r   <= dividend[31];
        mod_sel <= is_mod;
      end else if (busy) begin
        if (!sub[32]) begin
          r <= sub;
          q <= {q[30:0], 1'b1};
        end else begin
          r <= t;
          q <= {q[30:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (mod_sel) begin
      result = neg_r ? 32'd0 - r[31:0] : r[31:0];
    end else begin
      result = neg_q ? 32'd0 - q : q;
    end
  end

endmodule

// ===== rtl/acs_ctrl.sv =====
`timescale 1ns / 1ps

module acs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  acs_pkg::sts_t sts,
  output acs_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACT, S_FETCH, S_OPC, S_DEC, S_ARG, S_EX1, S_MEM, S_EX2, S_DIV,
    S_DONE
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.take      = (state == S_IDLE) && req_valid;
    cmd.act       = (state == S_ACT);
    cmd.fetch     = (state == S_FETCH);
    cmd.latch_opc = (state == S_OPC);
    cmd.decode    = (state == S_DEC);
    cmd.latch_arg = (state == S_ARG);
    cmd.exec1     = (state == S_EX1);
    cmd.latch_m   = (state == S_MEM);
    cmd.exec2     = (state == S_EX2);
    cmd.div_wait  = (state == S_DIV);
    cmd.finish    = (state == S_DONE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (req_valid) state <= S_ACT;
        S_ACT:   state <= sts.exec_go ? S_FETCH : S_DONE;
        S_FETCH: state <= sts.fetch_go ? S_OPC : S_DONE;
        S_OPC:   state <= S_DEC;
        S_DEC:   state <= sts.arg_go ? S_ARG : S_DONE;
        S_ARG:   state <= S_EX1;
        S_EX1:   state <= sts.mem_go ? S_MEM : S_DONE;
        S_MEM:   state <= S_EX2;
        S_EX2:   state <= sts.div_go ? S_DIV : S_DONE;
        S_DIV:   if (sts.div_done) state <= S_DONE;
        S_DONE:  if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/acs_datapath.sv =====
`timescale 1ns / 1ps

module acs_datapath #(
  parameter int MEM_WORDS  = acs_pkg::MEM_WORDS_DEF,
  parameter int IO_DEVICES = acs_pkg::IO_DEVICES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    req_op,
  input  logic [9:0]    req_address,
  input  logic [31:0]   req_value,
  input  logic [31:0]   req_io,
  acs_rsp_if.source     rsp,
  acs_cfg_if.sink       cfg,
  input  acs_pkg::cmd_t cmd,
  output acs_pkg::sts_t sts
);

  localparam int          AW      = $clog2(MEM_WORDS);
  localparam logic [31:0] MEM_LIM = 32'(MEM_WORDS);
  localparam logic [31:0] DEV_LIM = 32'(IO_DEVICES);

  acs_pkg::req_op_t rq_op;
  logic [9:0]       rq_addr;
  logic [31:0]      rq_value;
  logic [31:0]      rq_io;
  acs_pkg::mode_t   mode;
  logic [31:0]      pc;
  logic [31:0]      a;
  logic [31:0]      x;
  acs_pkg::err_t    err;
  logic [31:0]      det;
  acs_pkg::opcode_t opc;
  logic             opc_bad;
  logic [31:0]      arg;
  logic [31:0]      m;
  logic             io_taken;
  logic             io_wv;
  logic [3:0]       io_dev;
  logic [31:0]      io_wval;
  logic             out_valid;

  logic [31:0]   pc1;
  logic [31:0]   pc2;
  logic [31:0]   ea;
  logic [31:0]   rq_addr_w;
  logic          pc_ok;
  logic          pc1_ok;
  logic          ea_ok;
  logic          dev_ok;
  logic          rq_addr_ok;
  logic          priv;
  logic          take;
  logic          simple;
  logic          cond;
  logic          is_div;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic          div_start;
  logic          div_done;
  logic [31:0]   div_res;

  assign pc1        = pc + 32'd1;
  assign pc2        = pc + 32'd2;
  assign ea         = (opc == acs_pkg::OP_LOADX || opc == acs_pkg::OP_STOREX) ? arg + x : arg;
  assign rq_addr_w  = {22'd0, rq_addr};
  assign pc_ok      = pc < MEM_LIM;
  assign pc1_ok     = pc1 < MEM_LIM;
  assign ea_ok      = ea < MEM_LIM;
  assign dev_ok     = arg < DEV_LIM;
  assign rq_addr_ok = rq_addr_w < MEM_LIM;
  assign priv       = (mode != acs_pkg::MODE_SUP) &&
                      (opc inside {acs_pkg::OP_HALT, acs_pkg::OP_IN, acs_pkg::OP_OUT});
  assign simple     = opc inside {acs_pkg::OP_NOP, acs_pkg::OP_HALT, acs_pkg::OP_MOVAX,
                                  acs_pkg::OP_MOVXA, acs_pkg::OP_INCX, acs_pkg::OP_NEG};
  assign cond       = opc inside {[acs_pkg::OP_JZ : acs_pkg::OP_JP]};
  assign is_div     = (opc == acs_pkg::OP_DIV) || (opc == acs_pkg::OP_MOD);

  always_comb begin
    case (opc)
      acs_pkg::OP_JZ:  take = (a == 32'd0);
      acs_pkg::OP_JNZ: take = (a != 32'd0);
      acs_pkg::OP_JN:  take = a[31];
      acs_pkg::OP_JP:  take = (a != 32'd0) && !a[31];
      default:         take = 1'b0;
    endcase
  end

  assign sts.exec_go  = (rq_op == acs_pkg::REQ_EXEC) && (mode != acs_pkg::MODE_ZOMBIE) &&
                        (err == acs_pkg::ERR_OK);
  assign sts.fetch_go = pc_ok;
  assign sts.arg_go   = !opc_bad && !priv && !simple && !(cond && !take) && pc1_ok;
  assign sts.mem_go   = ea_ok && (opc inside {acs_pkg::OP_LOADM, acs_pkg::OP_LOADX,
                                              [acs_pkg::OP_ADD : acs_pkg::OP_MOD],
                                              acs_pkg::OP_RET});
  assign sts.div_go   = is_div && (m != 32'd0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || rsp.ready;

  // one word memory: request writes, stores and calls use its write port; fetches and operand reads use its read port
  always_comb begin
    we    = 1'b0;
    waddr = ea[AW-1:0];
    wdata = a;
    re    = 1'b0;
    raddr = ea[AW-1:0];
    if (cmd.act) begin
      we    = (rq_op == acs_pkg::REQ_WRITE) && rq_addr_ok;
      waddr = rq_addr_w[AW-1:0];
      wdata = rq_value;
    end
    if (cmd.fetch) begin
      re    = pc_ok;
      raddr = pc[AW-1:0];
    end
    if (cmd.decode) begin
      re    = pc1_ok;
      raddr = pc1[AW-1:0];
    end
    if (cmd.exec1) begin
      re = ea_ok;
      if (opc == acs_pkg::OP_STOREM || opc == acs_pkg::OP_STOREX) begin
        we = ea_ok;
      end
      if (opc == acs_pkg::OP_CALL) begin
        we    = ea_ok;
        wdata = pc2;
      end
    end
  end

  acs_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign div_start = cmd.exec2 && sts.div_go;

  acs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .is_mod  (opc == acs_pkg::OP_MOD),
    .dividend(a),
    .divisor (m),
    .done    (div_done),
    .result  (div_res)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= acs_pkg::MODE_SUP;
      pc        <= '0;
      a         <= '0;
      x         <= '0;
      err       <= acs_pkg::ERR_OK;
      det       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        mode <= acs_pkg::mode_t'(cfg.data);
      end

      if (cmd.take) begin
        rq_op    <= acs_pkg::req_op_t'(req_op);
        rq_addr  <= req_address;
        rq_value <= req_value;
        rq_io    <= req_io;
        io_taken <= 1'b0;
        io_wv    <= 1'b0;
        io_dev   <= '0;
        io_wval  <= '0;
      end

      if (cmd.act && rq_op == acs_pkg::REQ_SETPC) begin
        err <= acs_pkg::ERR_OK;
        det <= '0;
        pc  <= rq_addr_w;
      end

      if (cmd.fetch && !pc_ok) begin
        err <= acs_pkg::ERR_ADDR;
        det <= pc;
      end

      if (cmd.latch_opc) begin
        opc_bad <= rdata > acs_pkg::OPC_LAST;
        opc     <= acs_pkg::opcode_t'(rdata[4:0]);
      end

      if (cmd.decode) begin
        if (opc_bad) begin
          err <= acs_pkg::ERR_INV;
          det <= '0;
        end else if (priv) begin
          err <= acs_pkg::ERR_PRIV;
          det <= 32'(opc);
        end else begin
          case (opc)
            acs_pkg::OP_NOP:  pc <= pc1;
            acs_pkg::OP_HALT: begin
              err <= acs_pkg::ERR_HALT;
              det <= '0;
            end
            acs_pkg::OP_MOVAX: begin
              x  <= a;
              pc <= pc1;
            end
            acs_pkg::OP_MOVXA: begin
              a  <= x;
              pc <= pc1;
            end
            acs_pkg::OP_INCX: begin
              x  <= x + 32'd1;
              pc <= pc1;
            end
            acs_pkg::OP_NEG: begin
              a  <= 32'd0 - a;
              pc <= pc1;
            end
            default: begin
              if (cond && !take) begin
                pc <= pc2;
              end else if (!pc1_ok) begin
                err <= acs_pkg::ERR_ADDR;
                det <= pc1;
              end
            end
          endcase
        end
      end

      if (cmd.latch_arg) begin
        arg <= rdata;
      end

      if (cmd.exec1) begin
        case (opc)
          acs_pkg::OP_LOADI: begin
            a  <= arg;
            pc <= pc2;
          end
          acs_pkg::OP_STOREM, acs_pkg::OP_STOREX: begin
            if (ea_ok) begin
              pc <= pc2;
            end else begin
              err <= acs_pkg::ERR_ADDR;
              det <= ea;
            end
          end
          acs_pkg::OP_JMP, acs_pkg::OP_JZ, acs_pkg::OP_JNZ, acs_pkg::OP_JN,
          acs_pkg::OP_JP: pc <= arg;
          acs_pkg::OP_CALL: begin
            if (ea_ok) begin
              pc <= arg + 32'd1;
            end else begin
              err <= acs_pkg::ERR_ADDR;
              det <= ea;
            end
          end
          acs_pkg::OP_IN: begin
            if (dev_ok) begin
              a        <= rq_io;
              io_taken <= 1'b1;
              io_dev   <= arg[3:0];
              pc       <= pc2;
            end else begin
              err <= acs_pkg::ERR_DEV;
              det <= arg;
            end
          end
          acs_pkg::OP_OUT: begin
            if (dev_ok) begin
              io_wv   <= 1'b1;
              io_dev  <= arg[3:0];
              io_wval <= a;
              pc      <= pc2;
            end else begin
              err <= acs_pkg::ERR_DEV;
              det <= arg;
            end
          end
          acs_pkg::OP_SYSCALL: begin
            err <= acs_pkg::ERR_SYS;
            det <= arg;
          end
          default: begin
            // memory-operand ops
            if (!ea_ok) begin
              err <= acs_pkg::ERR_ADDR;
              det <= ea;
            end
          end
        endcase
      end

      if (cmd.latch_m) begin
        m <= rdata;
      end

      if (cmd.exec2) begin
        case (opc)
          acs_pkg::OP_LOADM, acs_pkg::OP_LOADX: begin
            a  <= m;
            pc <= pc2;
          end
          acs_pkg::OP_ADD: begin
            a  <= a + m;
            pc <= pc2;
          end
          acs_pkg::OP_SUB: begin
            a  <= a - m;
            pc <= pc2;
          end
          acs_pkg::OP_MUL: begin
            a  <= a * m;
            pc <= pc2;
          end
          acs_pkg::OP_DIV, acs_pkg::OP_MOD: begin
            if (m == 32'd0) begin
              err <= acs_pkg::ERR_DIV0;
              det <= arg;
            end
          end
          acs_pkg::OP_RET: pc <= m;
          default: ;
        endcase
      end

      if (cmd.div_wait && div_done) begin
        a  <= div_res;
        pc <= pc2;
      end

      if (cmd.finish) begin
        out_valid           <= 1'b1;
        rsp.status          <= (rq_op == acs_pkg::REQ_EXEC && mode == acs_pkg::MODE_ZOMBIE) ?
                               acs_pkg::ERR_OK : err;
        rsp.error_detail    <= det;
        rsp.program_counter <= pc;
        rsp.accumulator     <= a;
        rsp.index_value     <= x;
        rsp.io_read_taken   <= io_taken;
        rsp.io_write_valid  <= io_wv;
        rsp.io_device       <= io_dev;
        rsp.io_write_value  <= io_wval;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ===== rtl/accumulator_cpu_step_unit.sv =====
`timescale 1ns / 1ps

// Accumulator CPU step unit. One request at a time: a memory write, a PC set
// or a no-op request passes the activate and done states; an instruction
// goes through fetch, opcode latch and decode, then argument read and first
// execute if it has an argument, then operand read and second execute if it has
// a memory operand, as these reads take turns at the word memory; DIV and MOD
// then wait for the bit-serial divider. The result sits in an output register
// until taken; the next request is accepted once the current one has reached it.
module accumulator_cpu_step_unit #(
  parameter int MEM_WORDS  = acs_pkg::MEM_WORDS_DEF,
  parameter int IO_DEVICES = acs_pkg::IO_DEVICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  acs_req_if.sink   req,
  acs_rsp_if.source rsp,
  acs_cfg_if.sink   cfg
);

  acs_pkg::cmd_t cmd;
  acs_pkg::sts_t sts;
  logic          ready;

  assign req.ready = ready;

  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acs_datapath #(
    .MEM_WORDS (MEM_WORDS),
    .IO_DEVICES(IO_DEVICES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_op     (req.op),
    .req_address(req.address),
    .req_value  (req.value),
    .req_io     (req.io_read_value),
    .rsp        (rsp),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== rtl/acs_checker.sv =====
`timescale 1ns / 1ps
`include "accumulator_cpu_step_unit_defines.svh"

module acs_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_pc,
  input logic        rsp_taken,
  input logic        rsp_wv,
  input logic [3:0]  rsp_dev,
  input logic [31:0] rsp_wval
);

  `ACS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pc))
  `ACS_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)
  `ACS_ASSERT_IMP(a_io_excl, rsp_valid, !(rsp_taken && rsp_wv))
  `ACS_ASSERT_IMP(a_io_idle, rsp_valid && !rsp_taken && !rsp_wv, rsp_dev == 4'd0)
  `ACS_ASSERT_IMP(a_wval_idle, rsp_valid && !rsp_wv, rsp_wval == 32'd0)

endmodule

bind accumulator_cpu_step_unit acs_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_pc   (rsp.program_counter),
  .rsp_taken(rsp.io_read_taken),
  .rsp_wv   (rsp.io_write_valid),
  .rsp_dev  (rsp.io_device),
  .rsp_wval (rsp.io_write_value)
);

// ===== tb/accumulator_cpu_step_unit_tb.sv =====
`timescale 1ns / 1ps

module accumulator_cpu_step_unit_tb;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] detail;
    logic [31:0] pc;
    logic [31:0] acc;
    logic [31:0] xreg;
    logic        taken;
    logic        wvalid;
    logic [3:0]  dev;
    logic [31:0] wval;
  } cpu_view_t;

  class cpu_scoreboard;
    logic [31:0] pc, acc, xreg, detail;
    logic [2:0]  err;
    logic [1:0]  mode;
    logic [31:0] mem [1024];
    cpu_view_t   pending [$];
    cpu_view_t   cur;

    function void clear();
      pc = 0; acc = 0; xreg = 0; detail = 0; err = acs_pkg::ERR_OK;
      mode = acs_pkg::MODE_SUP;
    endfunction

    function void raise(logic [2:0] code, logic [31:0] d);
      err = code;
      detail = d;
    endfunction

    function bit rd(logic [31:0] a, output logic [31:0] v);
      if (a >= acs_pkg::MEM_WORDS_DEF) begin
        raise(acs_pkg::ERR_ADDR, a);
        return 0;
      end
      v = mem[a[9:0]];
      return 1;
    endfunction

    function bit wr(logic [31:0] a, logic [31:0] v);
      if (a >= acs_pkg::MEM_WORDS_DEF) begin
        raise(acs_pkg::ERR_ADDR, a);
        return 0;
      end
      mem[a[9:0]] = v;
      return 1;
    endfunction

    function bit dev_ok(logic [31:0] d);
      if (d >= acs_pkg::IO_DEVICES_DEF) begin
        raise(acs_pkg::ERR_DEV, d);
        return 0;
      end
      return 1;
    endfunction

    function logic [31:0] divide(logic [31:0] a, logic [31:0] b, bit rem);
      longint sa, sb, r;
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      r = rem ? sa % sb : sa / sb;
      return r[31:0];
    endfunction

    function void run(logic [31:0] io_in);
      logic [31:0] opc, arg, m, p;
      bit sup, take;
      p = pc;
      sup = (mode == acs_pkg::MODE_SUP);
      if (!rd(p, opc)) return;
      if (opc > acs_pkg::OPC_LAST) begin
        raise(acs_pkg::ERR_INV, 0);
        return;
      end
      if ((opc == acs_pkg::OP_HALT || opc == acs_pkg::OP_IN || opc == acs_pkg::OP_OUT) &&
          !sup) begin
        raise(acs_pkg::ERR_PRIV, opc);
        return;
      end
      case (opc)
        acs_pkg::OP_NOP: begin pc = p + 1; return; end
        acs_pkg::OP_HALT: begin raise(acs_pkg::ERR_HALT, 0); return; end
        acs_pkg::OP_MOVAX: begin xreg = acc; pc = p + 1; return; end
        acs_pkg::OP_MOVXA: begin acc = xreg; pc = p + 1; return; end
        acs_pkg::OP_INCX: begin xreg = xreg + 1; pc = p + 1; return; end
        acs_pkg::OP_NEG: begin acc = 0 - acc; pc = p + 1; return; end
        acs_pkg::OP_JZ, acs_pkg::OP_JNZ, acs_pkg::OP_JN, acs_pkg::OP_JP: begin
          if (opc == acs_pkg::OP_JZ) take = (acc == 0);
          else if (opc == acs_pkg::OP_JNZ) take = (acc != 0);
          else if (opc == acs_pkg::OP_JN) take = acc[31];
          else take = (acc != 0) && !acc[31];
          if (!take) begin
            pc = p + 2;
            return;
          end
        end
        default: ;
      endcase
      if (!rd(p + 1, arg)) return;
      case (opc)
        acs_pkg::OP_LOADI: begin acc = arg; pc = p + 2; end
        acs_pkg::OP_LOADM: if (rd(arg, m)) begin acc = m; pc = p + 2; end
        acs_pkg::OP_LOADX: if (rd(arg + xreg, m)) begin acc = m; pc = p + 2; end
        acs_pkg::OP_STOREM: if (wr(arg, acc)) pc = p + 2;
        acs_pkg::OP_STOREX: if (wr(arg + xreg, acc)) pc = p + 2;
        acs_pkg::OP_ADD, acs_pkg::OP_SUB, acs_pkg::OP_MUL, acs_pkg::OP_DIV,
        acs_pkg::OP_MOD: begin
          if (rd(arg, m)) begin
            if (opc == acs_pkg::OP_ADD) begin acc = acc + m; pc = p + 2; end
            else if (opc == acs_pkg::OP_SUB) begin acc = acc - m; pc = p + 2; end
            else if (opc == acs_pkg::OP_MUL) begin acc = acc * m; pc = p + 2; end
            else if (m == 0) raise(acs_pkg::ERR_DIV0, arg);
            else begin acc = divide(acc, m, opc == acs_pkg::OP_MOD); pc = p + 2; end
          end
        end
        acs_pkg::OP_JMP, acs_pkg::OP_JZ, acs_pkg::OP_JNZ, acs_pkg::OP_JN,
        acs_pkg::OP_JP: pc = arg;
        acs_pkg::OP_CALL: if (wr(arg, p + 2)) pc = arg + 1;
        acs_pkg::OP_RET: if (rd(arg, m)) pc = m;
        acs_pkg::OP_IN: if (dev_ok(arg)) begin
          acc = io_in; cur.taken = 1; cur.dev = arg[3:0]; pc = p + 2;
        end
        acs_pkg::OP_OUT: if (dev_ok(arg)) begin
          cur.wvalid = 1; cur.dev = arg[3:0]; cur.wval = acc; pc = p + 2;
        end
        acs_pkg::OP_SYSCALL: raise(acs_pkg::ERR_SYS, arg);
        default: ;
      endcase
    endfunction

    function void note(logic [1:0] op, logic [9:0] a, logic [31:0] v, logic [31:0] io);
      cur = '0;
      case (op)
        acs_pkg::REQ_WRITE: begin mem[a] = v; cur.status = err; end
        acs_pkg::REQ_EXEC: begin
          if (mode == acs_pkg::MODE_ZOMBIE) cur.status = acs_pkg::ERR_OK;
          else begin
            if (err == acs_pkg::ERR_OK) run(io);
            cur.status = err;
          end
        end
        acs_pkg::REQ_SETPC: begin
          err = acs_pkg::ERR_OK; detail = 0; pc = {22'b0, a}; cur.status = err;
        end
        default: cur.status = err;
      endcase
      cur.detail = detail; cur.pc = pc; cur.acc = acc; cur.xreg = xreg;
      pending.push_back(cur);
    endfunction

    function string check(cpu_view_t got);
      cpu_view_t e;
      string s;
      if (pending.size() == 0) return "result with no request outstanding";
      e = pending.pop_front();
      s = "";
      if (got.status !== e.status) s = {s, $sformatf(" status %0d/%0d", got.status, e.status)};
      if (got.detail !== e.detail) s = {s, $sformatf(" detail %h/%h", got.detail, e.detail)};
      if (got.pc !== e.pc) s = {s, $sformatf(" pc %h/%h", got.pc, e.pc)};
      if (got.acc !== e.acc) s = {s, $sformatf(" acc %h/%h", got.acc, e.acc)};
      if (got.xreg !== e.xreg) s = {s, $sformatf(" x %h/%h", got.xreg, e.xreg)};
      if (got.taken !== e.taken) s = {s, $sformatf(" taken %b/%b", got.taken, e.taken)};
      if (got.wvalid !== e.wvalid) s = {s, $sformatf(" wvalid %b/%b", got.wvalid, e.wvalid)};
      if (got.dev !== e.dev) s = {s, $sformatf(" dev %0d/%0d", got.dev, e.dev)};
      if (got.wval !== e.wval) s = {s, $sformatf(" wval %h/%h", got.wval, e.wval)};
      return s;
    endfunction
  endclass

  logic clk, rst;
  acs_req_if req_bus();
  acs_rsp_if rsp_bus();
  acs_cfg_if cfg_bus();

  accumulator_cpu_step_unit uut (
    .clk(clk), .rst(rst), .req(req_bus.sink), .rsp(rsp_bus.source), .cfg(cfg_bus.sink)
  );

  cpu_scoreboard cpu_sb;
  int errors;
  bit quiet;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("accumulator_cpu_step_unit: mismatch");
    $finish;
  end

  task report(string msg);
    $display("%0t mismatch:%s", $realtime, msg);
    errors++;
  endtask

  function bit idle_now();
    return !quiet && ($urandom_range(0, 99) < 13);
  endfunction

  function logic [31:0] prog_word();
    if ($urandom_range(0, 99) < 90) return $urandom_range(0, 25);
    if ($urandom_range(0, 1)) return $urandom_range(26, 31);
    return $urandom;
  endfunction

  always @(negedge clk) rsp_bus.ready <= rst ? 1'b0 : !idle_now();

  always @(posedge clk) begin
    cpu_view_t got;
    string msg;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.status = rsp_bus.status;
      got.detail = rsp_bus.error_detail;
      got.pc = rsp_bus.program_counter;
      got.acc = rsp_bus.accumulator;
      got.xreg = rsp_bus.index_value;
      got.taken = rsp_bus.io_read_taken;
      got.wvalid = rsp_bus.io_write_valid;
      got.dev = rsp_bus.io_device;
      got.wval = rsp_bus.io_write_value;
      msg = cpu_sb.check(got);
      if (msg != "") report(msg);
    end
  end

  task send(logic [1:0] op, logic [9:0] a, logic [31:0] v, logic [31:0] io);
    while (idle_now()) begin
      req_bus.valid = 0;
      @(negedge clk);
    end
    req_bus.valid = 1;
    req_bus.op = op;
    req_bus.address = a;
    req_bus.value = v;
    req_bus.io_read_value = io;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    cpu_sb.note(op, a, v, io);
    @(negedge clk);
  endtask

  task drain();
    req_bus.valid = 0;
    while (cpu_sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task set_mode(logic [1:0] m);
    drain();
    cfg_bus.valid = 1;
    cfg_bus.data = m;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cpu_sb.mode = m;
    @(negedge clk);
    cfg_bus.valid = 0;
  endtask

  task random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) send(acs_pkg::REQ_EXEC, 10'($urandom), $urandom, $urandom);
    else if (r < 80)
      send(acs_pkg::REQ_WRITE,
           10'($urandom_range(0, 7) ? $urandom_range(0, 63) : $urandom),
           prog_word(), $urandom);
    else if (r < 93)
      send(acs_pkg::REQ_SETPC,
           10'($urandom_range(0, 7) ? $urandom_range(0, 40) : $urandom),
           $urandom, $urandom);
    else if (r < 96) send(acs_pkg::REQ_NONE, 10'($urandom), $urandom, $urandom);
    else send(acs_pkg::REQ_EXEC, 10'($urandom), $urandom, $urandom);
  endtask

  initial begin
    logic [1:0] modes [6];
    int counts [6];
    cpu_sb = new();
    cpu_sb.clear();
    errors = 0;
    quiet = 0;
    rst = 1;
    req_bus.valid = 0; req_bus.op = acs_pkg::REQ_NONE; req_bus.address = 0;
    req_bus.value = 0; req_bus.io_read_value = 0;
    cfg_bus.valid = 0; cfg_bus.data = acs_pkg::MODE_SUP;
    rsp_bus.ready = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // preload every word so no read ever hits unwritten memory
    for (int i = 0; i < acs_pkg::MEM_WORDS_DEF; i++)
      send(acs_pkg::REQ_WRITE, 10'(i), prog_word(), $urandom);

    set_mode(acs_pkg::MODE_SUP);
    send(acs_pkg::REQ_WRITE, 10'd0, 32'h8000_0000, 32'h0);
    send(acs_pkg::REQ_WRITE, 10'd1023, 32'h7fff_ffff, 32'hffff_ffff);
    send(acs_pkg::REQ_WRITE, 10'd100, 32'(acs_pkg::OP_LOADI), 0);
    send(acs_pkg::REQ_WRITE, 10'd101, 32'h8000_0000, 0);
    send(acs_pkg::REQ_WRITE, 10'd102, 32'(acs_pkg::OP_DIV), 0);
    send(acs_pkg::REQ_WRITE, 10'd103, 32'd110, 0);
    send(acs_pkg::REQ_WRITE, 10'd104, 32'(acs_pkg::OP_IN), 0);
    send(acs_pkg::REQ_WRITE, 10'd105, 32'd15, 0);
    send(acs_pkg::REQ_WRITE, 10'd106, 32'(acs_pkg::OP_OUT), 0);
    send(acs_pkg::REQ_WRITE, 10'd107, 32'd16, 0);
    send(acs_pkg::REQ_WRITE, 10'd110, 32'hffff_ffff, 0);
    send(acs_pkg::REQ_SETPC, 10'd100, 0, 0);
    send(acs_pkg::REQ_EXEC, 0, 0, 32'h7fff_ffff);
    send(acs_pkg::REQ_EXEC, 0, 0, 32'h7fff_ffff);
    send(acs_pkg::REQ_EXEC, 0, 0, 32'h8000_0000);
    send(acs_pkg::REQ_EXEC, 0, 0, 0);
    send(acs_pkg::REQ_EXEC, 0, 0, 0);
    send(acs_pkg::REQ_NONE, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff);
    send(acs_pkg::REQ_SETPC, 10'd1023, 0, 0);
    send(acs_pkg::REQ_EXEC, 0, 0, 0);
    send(acs_pkg::REQ_SETPC, 10'd0, 0, 0);
    send(acs_pkg::REQ_EXEC, 0, 0, 0);

    modes = '{acs_pkg::MODE_SUP, acs_pkg::MODE_USER, acs_pkg::MODE_SUP,
              acs_pkg::MODE_ZOMBIE, acs_pkg::MODE_RSVD, acs_pkg::MODE_SUP};
    counts = '{150, 100, 120, 40, 80, 110};
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(modes[ph]);
      quiet = (ph == 2);
      for (int i = 0; i < counts[ph]; i++) random_item();
    end
    quiet = 0;
    drain();
    if (errors == 0) $display("accumulator_cpu_step_unit: match");
    else $display("accumulator_cpu_step_unit: mismatch");
    $finish;
  end

endmodule
